### sv/vector3_arith_normalize_unit_defines.svh
// assertion macros for the vector arithmetic and normalize unit
`ifndef VECTOR3_ARITH_NORMALIZE_UNIT_DEFINES_SVH
`define VECTOR3_ARITH_NORMALIZE_UNIT_DEFINES_SVH
`ifndef SYNTH
`define VANU_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vanu same-cycle check failed");
`define VANU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vanu next-cycle check failed");
`else
`define VANU_ASSERT_SAME(lbl, ante, cons)
`define VANU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### sv/vanu_pkg.sv
// shared types and constants of the vector arithmetic and normalize unit
package vanu_pkg;
  localparam int FRAC_BITS   = 16;
  localparam int SQRT_STAGES = 32;
  localparam int DIV_W       = 32 + FRAC_BITS;
  localparam int DIV_IN      = SQRT_STAGES + 1;
  localparam int SB_LAST     = DIV_IN + DIV_W;

  localparam logic [31:0] MAX32 = 32'h7FFF_FFFF;
  localparam logic [31:0] MIN32 = 32'h8000_0000;
  localparam logic signed [63:0] MAX64 = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] MIN64 = 64'shFFFF_FFFF_8000_0000;

  localparam logic [3:0] CMD_MAG  = 4'd8;
  localparam logic [3:0] CMD_NORM = 4'd9;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } alu_op_t;

  typedef logic [2:0][31:0] vec_t;

  typedef struct packed {
    logic [3:0]  cmd;
    vec_t        a;
    vec_t        d;
    vec_t        res;
    logic [2:0]  rov;
    logic [31:0] root;
  } sb_t;
endpackage

### sv/vanu_if.sv
// input and result channel interfaces
interface vanu_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         command;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic signed [31:0] a_z;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic signed [31:0] b_z;
  logic signed [31:0] scalar_value;
  modport source (output valid, command, a_x, a_y, a_z, b_x, b_y, b_z, scalar_value,
                  input ready);
  modport sink (input valid, command, a_x, a_y, a_z, b_x, b_y, b_z, scalar_value,
                output ready);
endinterface

interface vanu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] r_x;
  logic signed [31:0] r_y;
  logic signed [31:0] r_z;
  logic [30:0]        length;
  logic               divide_by_zero;
  logic               overflow;
  modport source (output valid, r_x, r_y, r_z, length, divide_by_zero, overflow,
                  input ready);
  modport sink (input valid, r_x, r_y, r_z, length, divide_by_zero, overflow,
                output ready);
endinterface

### sv/vanu_lane.sv
// one lane: add, subtract, multiply and square of one component
module vanu_lane (
  input  logic               clk,
  input  logic               en,
  input  logic [1:0]         op,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic [31:0]        res,
  output logic               ovf,
  output logic [63:0]        sq
);
  import vanu_pkg::*;

  logic [1:0]         op_r;
  logic signed [32:0] sum_r;
  logic signed [63:0] prod_r;
  logic [63:0]        sq_r;
  logic signed [63:0] a_w;
  logic signed [63:0] b_w;
  logic signed [63:0] shifted;

  assign a_w = 64'(a);
  assign b_w = 64'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      op_r   <= op;
      sum_r  <= (alu_op_t'(op) == OP_SUB) ? (33'(a) - 33'(b)) : (33'(a) + 33'(b));
      prod_r <= a_w * b_w;
      sq_r   <= $unsigned(a_w * a_w);
    end
  end

  assign shifted = prod_r >>> FRAC_BITS;
  assign sq      = sq_r;

  always_comb begin
    res = '0;
    ovf = 1'b0;
    case (alu_op_t'(op_r))
      OP_ADD, OP_SUB: begin
        ovf = sum_r[32] ^ sum_r[31];
        res = ovf ? (sum_r[32] ? MIN32 : MAX32) : sum_r[31:0];
      end
      OP_MUL: begin
        if (shifted > MAX64) begin
          ovf = 1'b1;
          res = MAX32;
        end else if (shifted < MIN64) begin
          ovf = 1'b1;
          res = MIN32;
        end else begin
          res = shifted[31:0];
        end
      end
      default: begin
        res = '0;
        ovf = 1'b0;
      end
    endcase
  end
endmodule

### sv/vanu_sqrt.sv
// pipelined integer square root, one root bit per stage
module vanu_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad,
  output logic [31:0] root
);
  import vanu_pkg::*;

  logic [33:0] rem_r  [SQRT_STAGES];
  logic [31:0] root_r [SQRT_STAGES];
  logic [63:0] rad_r  [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic [33:0] rem_p;
    logic [31:0] root_p;
    logic [63:0] rad_p;
    logic [35:0] t;
    logic [35:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad;
    end else begin : g_next
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign rad_p  = rad_r[k-1];
    end

    assign t     = {rem_p, rad_p[63:62]};
    assign trial = {2'b00, root_p, 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? 34'(t - trial) : t[33:0];
        root_r[k] <= {root_p[30:0], ge};
        rad_r[k]  <= {rad_p[61:0], 2'b00};
      end
    end
  end

  assign root = root_r[SQRT_STAGES-1];
endmodule

### sv/vanu_div.sv
// pipelined restoring divider, one quotient bit per stage
module vanu_div (
  input  logic                           clk,
  input  logic                           en,
  input  logic [vanu_pkg::DIV_W-1:0]     num,
  input  logic [31:0]                    den,
  output logic [vanu_pkg::DIV_W-1:0]     quo
);
  import vanu_pkg::*;

  logic [31:0]      rem_r [DIV_W];
  logic [DIV_W-1:0] nq_r  [DIV_W];
  logic [31:0]      den_r [DIV_W];

  for (genvar k = 0; k < DIV_W; k++) begin : g_stage
    logic [31:0]      rem_p;
    logic [DIV_W-1:0] nq_p;
    logic [31:0]      den_p;
    logic [32:0]      t;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_p = '0;
      assign nq_p  = num;
      assign den_p = den;
    end else begin : g_next
      assign rem_p = rem_r[k-1];
      assign nq_p  = nq_r[k-1];
      assign den_p = den_r[k-1];
    end

    assign t  = {rem_p, nq_p[DIV_W-1]};
    assign ge = (t >= {1'b0, den_p});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? 32'(t - {1'b0, den_p}) : t[31:0];
        nq_r[k]  <= {nq_p[DIV_W-2:0], ge};
        den_r[k] <= den_p;
      end
    end
  end

  assign quo = nq_r[DIV_W-1];
endmodule

### sv/vector3_arith_normalize_unit.sv
// top level of the vector arithmetic and normalize unit
// Takes one item per clock while the output is not stalled and returns one
// result per item, in order, after the lane multiply and squaring register,
// the sum-of-squares register, a 32-stage square root, a 32 + FRAC_BITS stage
// divider per lane shared by the divide and normalize commands, and the output
// register. Every item passes the full pipeline; the pipeline only halts while a
// result waits on the output.
module vector3_arith_normalize_unit (
  input logic        clk,
  input logic        rst_n,
  vanu_in_if.sink    in_ch,
  vanu_out_if.source out_ch
);
  import vanu_pkg::*;

  `include "vector3_arith_normalize_unit_defines.svh"

  logic             adv;
  logic [SB_LAST:0] vld_r;
  sb_t              sb_r   [SB_LAST+1];
  sb_t              sb_nxt [SB_LAST+1];
  vec_t             a_in;
  vec_t             b_in;
  vec_t             opnd;
  vec_t             lane_res;
  logic [2:0]       lane_ovf;
  logic [2:0][63:0] lane_sq;
  logic [63:0]      sum_r;
  logic [31:0]      root;
  logic [2:0][DIV_W-1:0] num_mag;
  logic [2:0][31:0]      den_mag;
  logic [2:0][DIV_W-1:0] quo;

  logic               out_valid_r;
  logic signed [31:0] r_x_r, r_y_r, r_z_r;
  logic [30:0]        length_r;
  logic               dbz_r, ovf_r;

  vec_t        fin_r;
  logic        fin_dbz, fin_ovf;
  logic [30:0] fin_len;
  sb_t         ent;
  sb_t         fin;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  assign a_in = {in_ch.a_z, in_ch.a_y, in_ch.a_x};
  assign b_in = {in_ch.b_z, in_ch.b_y, in_ch.b_x};

  for (genvar i = 0; i < 3; i++) begin : g_lane
    assign opnd[i] = in_ch.command[2] ? in_ch.scalar_value : b_in[i];
    vanu_lane u_lane (
      .clk (clk),
      .en  (adv),
      .op  (in_ch.command[1:0]),
      .a   (a_in[i]),
      .b   (opnd[i]),
      .res (lane_res[i]),
      .ovf (lane_ovf[i]),
      .sq  (lane_sq[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r <= lane_sq[0] + lane_sq[1] + lane_sq[2];
    end
  end

  vanu_sqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .rad  (sum_r),
    .root (root)
  );

  // divider entry, aligned with the square root output
  assign ent = sb_r[DIV_IN];

  for (genvar i = 0; i < 3; i++) begin : g_div
    logic [31:0] a_abs;
    logic [31:0] d_abs;
    assign a_abs      = ent.a[i][31] ? 32'(32'd0 - ent.a[i]) : ent.a[i];
    assign d_abs      = ent.d[i][31] ? 32'(32'd0 - ent.d[i]) : ent.d[i];
    assign num_mag[i] = {a_abs, {FRAC_BITS{1'b0}}};
    assign den_mag[i] = (ent.cmd == CMD_NORM) ? root : d_abs;
    vanu_div u_div (
      .clk (clk),
      .en  (adv),
      .num (num_mag[i]),
      .den (den_mag[i]),
      .quo (quo[i])
    );
  end

  always_comb begin
    sb_nxt[0].cmd  = in_ch.command;
    sb_nxt[0].a    = a_in;
    sb_nxt[0].d    = opnd;
    sb_nxt[0].res  = '0;
    sb_nxt[0].rov  = '0;
    sb_nxt[0].root = '0;
    for (int k = 1; k <= SB_LAST; k++) begin
      sb_nxt[k] = sb_r[k-1];
    end
    sb_nxt[1].res        = lane_res;
    sb_nxt[1].rov        = lane_ovf;
    sb_nxt[DIV_IN+1].root = root;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= SB_LAST; k++) begin
        sb_r[k] <= sb_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[SB_LAST-1:0], in_ch.valid};
    end
  end

  assign fin = sb_r[SB_LAST];

  always_comb begin
    logic        is_vec, is_sc, is_mag, is_norm, is_div;
    logic        dz, neg;
    logic [31:0] den;
    is_vec  = (fin.cmd[3:2] == 2'b00);
    is_sc   = (fin.cmd[3:2] == 2'b01);
    is_mag  = (fin.cmd == CMD_MAG);
    is_norm = (fin.cmd == CMD_NORM);
    is_div  = ((is_vec || is_sc) && (alu_op_t'(fin.cmd[1:0]) == OP_DIV)) || is_norm;
    fin_r   = '0;
    fin_dbz = 1'b0;
    fin_ovf = 1'b0;
    fin_len = '0;
    dz      = 1'b0;
    neg     = 1'b0;
    den     = '0;
    if (is_mag || is_norm) begin
      if (fin.root[31]) begin
        fin_len = MAX32[30:0];
        fin_ovf = 1'b1;
      end else begin
        fin_len = fin.root[30:0];
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (is_div) begin
        den = is_norm ? fin.root : fin.d[i];
        dz  = (den == '0);
        neg = fin.a[i][31] ^ (fin.d[i][31] && !is_norm);
        if (dz) begin
          fin_dbz = 1'b1;
          if (fin.a[i][31]) begin
            fin_r[i] = MIN32;
          end else if (fin.a[i] != '0) begin
            fin_r[i] = MAX32;
          end
        end else if (neg) begin
          if (quo[i] > DIV_W'(MIN32)) begin
            fin_r[i] = MIN32;
            fin_ovf  = 1'b1;
          end else begin
            fin_r[i] = 32'(32'd0 - quo[i][31:0]);
          end
        end else begin
          if (quo[i] > DIV_W'(MAX32)) begin
            fin_r[i] = MAX32;
            fin_ovf  = 1'b1;
          end else begin
            fin_r[i] = quo[i][31:0];
          end
        end
      end else if (is_vec || is_sc) begin
        fin_r[i] = fin.res[i];
        fin_ovf  = fin_ovf | fin.rov[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[SB_LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_x_r    <= fin_r[0];
      r_y_r    <= fin_r[1];
      r_z_r    <= fin_r[2];
      length_r <= fin_len;
      dbz_r    <= fin_dbz;
      ovf_r    <= fin_ovf;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.r_x            = r_x_r;
  assign out_ch.r_y            = r_y_r;
  assign out_ch.r_z            = r_z_r;
  assign out_ch.length         = length_r;
  assign out_ch.divide_by_zero = dbz_r;
  assign out_ch.overflow       = ovf_r;

  `VANU_ASSERT_NEXT(a_last_to_out, vld_r[SB_LAST] && adv, out_valid_r)
  `VANU_ASSERT_NEXT(a_accept_enters, in_ch.valid && in_ch.ready, vld_r[0])
  `VANU_ASSERT_SAME(a_stall_blocks_input, out_valid_r && !out_ch.ready, !in_ch.ready)
endmodule
